/* design/kts_pkg.sv */
// ============================================================================
// Trajectory smoother package
// Shared types, register indexes, reset values and state encodings for the
// trajectory smoother and its arithmetic units.
// ============================================================================
package kts_pkg;

    // Field widths of the item, result and configuration transfers.
    localparam int DELTA_WIDTH     = 32;
    localparam int NOISE_WIDTH     = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROCESS_NOISE_X     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEASUREMENT_NOISE_X = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROCESS_NOISE_Y     = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEASUREMENT_NOISE_Y = 2'd3;

    // Register reset values.
    localparam logic [NOISE_WIDTH-1:0] PROCESS_NOISE_RESET     = 32'd66;
    localparam logic [NOISE_WIDTH-1:0] MEASUREMENT_NOISE_RESET = 32'd16384;

    // Saturation bounds of the corrected motion, held in 36 bits.
    localparam logic signed [35:0] SAT_HI = 36'sh07FFFFFFF;
    localparam logic signed [35:0] SAT_LO = 36'shF80000000;

    // Input item: motion of one frame.
    typedef struct packed {
        logic signed [DELTA_WIDTH-1:0] delta_x;
        logic signed [DELTA_WIDTH-1:0] delta_y;
        logic                          first_frame;
    } item_t;

    // Result item: smoothed motion of one frame.
    typedef struct packed {
        logic signed [DELTA_WIDTH-1:0] new_delta_x;
        logic signed [DELTA_WIDTH-1:0] new_delta_y;
    } result_t;

    // Filter sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREDICT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RESIDUAL,
        ST_SCALE_WAIT,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_OUTPUT,
        ST_EMIT
    } seq_state_t;

    // Multiply-accumulate unit phases.
    typedef enum logic [1:0] {
        MAC_IDLE,
        MAC_MUL,
        MAC_ADD
    } mac_phase_t;

endpackage

/* design/kts_divider.sv */
// ============================================================================
// Gain divider
// Restoring divider that forms floor(dividend * 2^F / divisor) one quotient
// bit per cycle. The quotient never exceeds 2^F because the dividend is not
// larger than the divisor. A zero divisor gives a zero quotient.
// ============================================================================
module kts_divider #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [31:0]              dividend,
    input  logic [32:0]              divisor,
    output logic [FRACTION_BITS:0]   quotient,
    output logic                     done
);

    localparam int STEPS = FRACTION_BITS + 1;
    localparam int CNTW  = $clog2(STEPS + 1);

    logic [CNTW-1:0]          cnt_reg;
    logic                     done_reg;
    logic                     zero_reg;
    logic [33:0]              rem_reg;
    logic [32:0]              den_reg;
    logic [FRACTION_BITS:0]   q_reg;

    logic                     ge;
    logic [33:0]              rem_diff;
    logic [33:0]              rem_step;

    // One compare and subtract per cycle.
    assign ge       = rem_reg >= {1'b0, den_reg};
    assign rem_diff = rem_reg - {1'b0, den_reg};
    assign rem_step = ge ? rem_diff : rem_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cnt_reg == '0)
            begin
                if (start)
                begin
                    cnt_reg <= CNTW'(STEPS);
                end
            end
            else
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (cnt_reg == '0)
        begin
            if (start)
            begin
                rem_reg  <= {2'b00, dividend};
                den_reg  <= divisor;
                zero_reg <= (divisor == '0);
                q_reg    <= '0;
            end
        end
        else
        begin
            rem_reg <= {rem_step[32:0], 1'b0};
            q_reg   <= {q_reg[FRACTION_BITS-1:0], ge};
        end
    end

    assign quotient = zero_reg ? '0 : q_reg;
    assign done     = done_reg;

endmodule

/* design/kts_mac.sv */
// ============================================================================
// Gain multiplier
// Forms floor(gain * operand / 2^F) with one (F+1) x 32 bit multiplier,
// taking the operand in 32-bit chunks from the top down. Each chunk takes
// a multiply phase and then an accumulate phase.
// ============================================================================
module kts_mac #(
    parameter int POSITION_WIDTH = 48,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [FRACTION_BITS:0]      gain,
    input  logic [POSITION_WIDTH-1:0]   operand,
    output logic [POSITION_WIDTH-1:0]   result,
    output logic                        done
);

    localparam int NCH = (POSITION_WIDTH + 31) / 32;
    localparam int OPW = NCH * 32;
    localparam int PRW = FRACTION_BITS + 33;
    localparam int AW  = OPW + FRACTION_BITS + 1;
    localparam int CW  = $clog2(NCH + 1);

    kts_pkg::mac_phase_t      phase_reg, phase_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic [FRACTION_BITS:0]   gain_reg, gain_next;
    logic [OPW-1:0]           op_reg, op_next;
    logic [PRW-1:0]           prod_reg, prod_next;
    logic [AW-1:0]            acc_reg, acc_next;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kts_pkg::MAC_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        gain_reg <= gain_next;
        op_reg   <= op_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // Chunk sequencing: multiply, then shift the sum up a chunk and add.
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        gain_next  = gain_reg;
        op_next    = op_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        unique case (phase_reg)
            kts_pkg::MAC_IDLE:
            begin
                if (start)
                begin
                    gain_next  = gain;
                    op_next    = OPW'(operand);
                    acc_next   = '0;
                    cnt_next   = CW'(NCH);
                    phase_next = kts_pkg::MAC_MUL;
                end
            end
            kts_pkg::MAC_MUL:
            begin
                prod_next  = PRW'(gain_reg) * PRW'(op_reg[OPW-1 -: 32]);
                op_next    = op_reg << 32;
                phase_next = kts_pkg::MAC_ADD;
            end
            kts_pkg::MAC_ADD:
            begin
                acc_next = (acc_reg << 32) + AW'(prod_reg);
                if (cnt_reg == CW'(1))
                begin
                    done_next  = 1'b1;
                    phase_next = kts_pkg::MAC_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    phase_next = kts_pkg::MAC_MUL;
                end
            end
            default:
            begin
                phase_next = kts_pkg::MAC_IDLE;
            end
        endcase
    end

    assign result = acc_reg[FRACTION_BITS +: POSITION_WIDTH];
    assign done   = done_reg;

endmodule

/* design/kalman_trajectory_smoother.sv */
// ============================================================================
// Kalman trajectory smoother
// Two scalar Kalman filters, x and y, run in turn by one sequencer over a
// shared divider and a shared multiplier, smoothing per-frame motion.
// ============================================================================
// Each accepted item adds its motion to the x and y trajectory totals, runs
// one filter step per axis and returns one result: the motion corrected by
// the filtered trajectory, saturated to 32 bits. The block takes one item at
// a time; item_stall stays high from acceptance until the result is loaded
// into the output register. When first_frame is set, each axis resets its
// estimate and variance and skips the divider and the multiplier. The gain
// divider forms one quotient bit per cycle, and the (FRACTION_BITS+1) x 32
// bit multiplier takes its operand in 32-bit chunks and is used twice per
// axis; both are shared by the two axes, which are processed one after the
// other.
module kalman_trajectory_smoother #(
    parameter int POSITION_WIDTH = 48,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  kts_pkg::item_t                        item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output kts_pkg::result_t                      result,
    input  logic                                  cfg_write,
    input  logic [kts_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [kts_pkg::NOISE_WIDTH-1:0]       cfg_data
);

    localparam int PW = POSITION_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int EW = PW + 2;

    localparam logic [F:0]             ONE_GAIN     = {1'b1, {F{1'b0}}};
    localparam logic [31:0]            ONE_VARIANCE = 32'(ONE_GAIN);
    localparam logic signed [EW-1:0]   CLAMP_HI     = EW'(64'sd8589934592);
    localparam logic signed [EW-1:0]   CLAMP_LO     = EW'(-64'sd8589934592);

    kts_pkg::seq_state_t      state_reg, state_next;
    logic                     axis_reg, axis_next;

    logic [31:0]              q_noise_reg [2];
    logic [31:0]              r_noise_reg [2];

    logic [PW-1:0]            total_reg [2];
    logic [PW-1:0]            total_next [2];
    logic [PW-1:0]            est_reg [2];
    logic [PW-1:0]            est_next [2];
    logic [31:0]              var_reg [2];
    logic [31:0]              var_next [2];

    logic signed [31:0]       delta_reg [2];
    logic                     first_reg;
    logic [31:0]              pp_reg, pp_next;
    logic [F:0]               gain_reg, gain_next;
    logic                     neg_reg, neg_next;
    logic [31:0]              nd_reg [2];
    logic [31:0]              nd_next [2];

    logic                     result_valid_reg;
    kts_pkg::result_t         result_reg;

    logic                     item_accept;
    logic                     result_load;

    // Shared unit handshakes.
    logic                     div_start;
    logic [32:0]              div_den;
    logic [F:0]               div_quot;
    logic                     div_done;
    logic                     mac_start;
    logic [F:0]               mac_gain;
    logic [PW-1:0]            mac_operand;
    logic [PW-1:0]            mac_result;
    logic                     mac_done;

    // Per-axis combinational values.
    logic signed [31:0]       cur_delta;
    logic [PW-1:0]            delta_ext;
    logic [32:0]              var_sum;
    logic [31:0]              pp_sat;
    logic [PW-1:0]            res_diff;
    logic [PW-1:0]            res_mag;
    logic [PW-1:0]            out_diff;
    logic signed [EW-1:0]     out_wide;
    logic signed [34:0]       diff_clamped;
    logic signed [35:0]       out_sum;
    logic [31:0]              out_sat;

    assign item_stall  = (state_reg != kts_pkg::ST_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign result_load = (state_reg == kts_pkg::ST_EMIT)
                         && (!result_valid_reg || !result_stall);

    // Prediction: variance plus process noise, saturated to 32 bits.
    assign cur_delta = delta_reg[axis_reg];
    assign delta_ext = {{(PW-32){cur_delta[31]}}, cur_delta};
    assign var_sum   = {1'b0, var_reg[axis_reg]} + {1'b0, q_noise_reg[axis_reg]};
    assign pp_sat    = var_sum[32] ? '1 : var_sum[31:0];
    assign div_den   = {1'b0, pp_reg} + {1'b0, r_noise_reg[axis_reg]};

    // Residual between trajectory total and estimate, as sign and magnitude.
    assign res_diff = total_reg[axis_reg] - est_reg[axis_reg];
    assign res_mag  = res_diff[PW-1] ? (PW'(0) - res_diff) : res_diff;

    // Corrected motion: delta plus clamped (estimate - total), saturated.
    assign out_diff = est_reg[axis_reg] - total_reg[axis_reg];
    assign out_wide = {{2{out_diff[PW-1]}}, out_diff};
    always_comb
    begin
        priority if (out_wide > CLAMP_HI)
        begin
            diff_clamped = 35'sh200000000;
        end
        else if (out_wide < CLAMP_LO)
        begin
            diff_clamped = 35'sh600000000;
        end
        else
        begin
            diff_clamped = out_wide[34:0];
        end
    end
    assign out_sum = {{4{cur_delta[31]}}, cur_delta} + {diff_clamped[34], diff_clamped};
    always_comb
    begin
        priority if (out_sum > kts_pkg::SAT_HI)
        begin
            out_sat = 32'h7FFFFFFF;
        end
        else if (out_sum < kts_pkg::SAT_LO)
        begin
            out_sat = 32'h80000000;
        end
        else
        begin
            out_sat = out_sum[31:0];
        end
    end

    // Shared gain divider.
    kts_divider #(
        .FRACTION_BITS (F)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pp_reg),
        .divisor  (div_den),
        .quotient (div_quot),
        .done     (div_done)
    );

    // Shared gain multiplier.
    kts_mac #(
        .POSITION_WIDTH (PW),
        .FRACTION_BITS  (F)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mac_start),
        .gain    (mac_gain),
        .operand (mac_operand),
        .result  (mac_result),
        .done    (mac_done)
    );

    // Sequencer state and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kts_pkg::ST_IDLE;
            axis_reg  <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                total_reg[i] <= '0;
                est_reg[i]   <= '0;
                var_reg[i]   <= ONE_VARIANCE;
            end
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            for (int i = 0; i < 2; i++)
            begin
                total_reg[i] <= total_next[i];
                est_reg[i]   <= est_next[i];
                var_reg[i]   <= var_next[i];
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_noise_reg[0] <= kts_pkg::PROCESS_NOISE_RESET;
            r_noise_reg[0] <= kts_pkg::MEASUREMENT_NOISE_RESET;
            q_noise_reg[1] <= kts_pkg::PROCESS_NOISE_RESET;
            r_noise_reg[1] <= kts_pkg::MEASUREMENT_NOISE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                kts_pkg::REG_PROCESS_NOISE_X:     q_noise_reg[0] <= cfg_data;
                kts_pkg::REG_MEASUREMENT_NOISE_X: r_noise_reg[0] <= cfg_data;
                kts_pkg::REG_PROCESS_NOISE_Y:     q_noise_reg[1] <= cfg_data;
                kts_pkg::REG_MEASUREMENT_NOISE_Y: r_noise_reg[1] <= cfg_data;
                default:                          q_noise_reg[0] <= q_noise_reg[0];
            endcase
        end
    end

    // Item capture and per-step working registers.
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            delta_reg[0] <= item.delta_x;
            delta_reg[1] <= item.delta_y;
            first_reg    <= item.first_frame;
        end
        pp_reg    <= pp_next;
        gain_reg  <= gain_next;
        neg_reg   <= neg_next;
        nd_reg[0] <= nd_next[0];
        nd_reg[1] <= nd_next[1];
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg.new_delta_x <= nd_reg[0];
            result_reg.new_delta_y <= nd_reg[1];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Next state and datapath control.
    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        total_next  = total_reg;
        est_next    = est_reg;
        var_next    = var_reg;
        pp_next     = pp_reg;
        gain_next   = gain_reg;
        neg_next    = neg_reg;
        nd_next     = nd_reg;
        div_start   = 1'b0;
        mac_start   = 1'b0;
        mac_gain    = gain_reg;
        mac_operand = res_mag;
        unique case (state_reg)
            kts_pkg::ST_IDLE:
            begin
                if (item_accept)
                begin
                    axis_next  = 1'b0;
                    state_next = kts_pkg::ST_PREDICT;
                end
            end
            kts_pkg::ST_PREDICT:
            begin
                total_next[axis_reg] = total_reg[axis_reg] + delta_ext;
                pp_next              = pp_sat;
                if (first_reg)
                begin
                    est_next[axis_reg] = '0;
                    var_next[axis_reg] = ONE_VARIANCE;
                    state_next         = kts_pkg::ST_OUTPUT;
                end
                else
                begin
                    state_next = kts_pkg::ST_DIV_GO;
                end
            end
            kts_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = kts_pkg::ST_DIV_WAIT;
            end
            kts_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    gain_next  = div_quot;
                    state_next = kts_pkg::ST_RESIDUAL;
                end
            end
            kts_pkg::ST_RESIDUAL:
            begin
                neg_next    = res_diff[PW-1];
                mac_start   = 1'b1;
                mac_gain    = gain_reg;
                mac_operand = res_mag;
                state_next  = kts_pkg::ST_SCALE_WAIT;
            end
            kts_pkg::ST_SCALE_WAIT:
            begin
                if (mac_done)
                begin
                    if (neg_reg)
                    begin
                        est_next[axis_reg] = est_reg[axis_reg] - mac_result;
                    end
                    else
                    begin
                        est_next[axis_reg] = est_reg[axis_reg] + mac_result;
                    end
                    state_next = kts_pkg::ST_VAR_GO;
                end
            end
            kts_pkg::ST_VAR_GO:
            begin
                mac_start   = 1'b1;
                mac_gain    = ONE_GAIN - gain_reg;
                mac_operand = {{(PW-32){1'b0}}, pp_reg};
                state_next  = kts_pkg::ST_VAR_WAIT;
            end
            kts_pkg::ST_VAR_WAIT:
            begin
                if (mac_done)
                begin
                    var_next[axis_reg] = mac_result[31:0];
                    state_next         = kts_pkg::ST_OUTPUT;
                end
            end
            kts_pkg::ST_OUTPUT:
            begin
                nd_next[axis_reg] = out_sat;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = kts_pkg::ST_PREDICT;
                end
                else
                begin
                    state_next = kts_pkg::ST_EMIT;
                end
            end
            kts_pkg::ST_EMIT:
            begin
                if (result_load)
                begin
                    state_next = kts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// Trajectory smoother testbench
// Drives motion transfers into the smoother and checks every smoothed result
// against a cycle-free model of the two axis filters kept inside this bench.
// A short table of hand-picked frames comes first. Random phases follow,
// each under its own noise setting. A last phase runs both filters with a
// gain of one and large motion steps, with no idling on either side.
// ============================================================================
module tb;

    localparam int POS_W      = 48;
    localparam int FRAC       = 16;
    localparam int AXIS_X     = 0;
    localparam int AXIS_Y     = 1;
    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASES     = 10;
    localparam int PHASE_FRAMES = 110;
    localparam int DRIFT_FRAMES = 40;

    localparam logic [16:0] GAIN_ONE      = 17'd1 << FRAC;
    localparam logic [31:0] VARIANCE_ONE  = 32'd1 << FRAC;
    localparam logic [31:0] DELTA_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] DELTA_MIN     = 32'h8000_0000;
    localparam logic [31:0] NOISE_MAX     = 32'hFFFF_FFFF;

    // One row of the directed table; pinned rows carry a hand-written result.
    typedef struct packed {
        logic             pinned;
        kts_pkg::result_t motion;
        kts_pkg::item_t   frame;
    } frame_row_t;

    typedef struct packed {
        logic             pinned;
        kts_pkg::result_t motion;
    } pinned_t;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    kts_pkg::item_t   item;
    logic             result_valid;
    logic             result_stall;
    kts_pkg::result_t result;
    logic             cfg_write;
    logic [kts_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [kts_pkg::NOISE_WIDTH-1:0]     cfg_data;

    // Filter state and noise setting of the bench model, per axis.
    logic [POS_W-1:0] track_total [2];
    logic [POS_W-1:0] track_est   [2];
    logic [31:0]      track_var   [2];
    logic [31:0]      q_noise     [2];
    logic [31:0]      r_noise     [2];

    kts_pkg::result_t expected_motion [$];
    pinned_t          pinned_q [$];
    frame_row_t       frame_table [$];

    int  fault_count;
    int  idle_cycles;
    int  burst_left;
    bit  quiet_phase;
    kts_pkg::result_t predicted;
    pinned_t pin;

    kalman_trajectory_smoother #(
        .POSITION_WIDTH (POS_W),
        .FRACTION_BITS  (FRAC)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // One filter step of one axis; returns the corrected motion.
    function automatic logic [31:0] smooth_axis(input int ax, input logic [31:0] delta,
                                                input logic first);
        logic [63:0]        delta_wide;
        logic [32:0]        pp;
        logic [33:0]        den;
        logic [63:0]        quot;
        logic [16:0]        gain;
        logic [POS_W-1:0]   resid;
        logic [POS_W-1:0]   mag;
        logic [95:0]        prod;
        logic [63:0]        var_prod;
        logic               neg;
        logic signed [63:0] diff;
        logic signed [63:0] sum;
        delta_wide = {{32{delta[31]}}, delta};
        track_total[ax] = track_total[ax] + delta_wide[POS_W-1:0];
        if (first)
        begin
            track_est[ax] = '0;
            track_var[ax] = VARIANCE_ONE;
        end
        else
        begin
            // Predicted variance saturates; a zero denominator gives zero gain.
            pp = {1'b0, track_var[ax]} + {1'b0, q_noise[ax]};
            if (pp[32])
                pp = 33'h0_FFFF_FFFF;
            den = {1'b0, pp} + {2'b0, r_noise[ax]};
            quot = (den == 0) ? 64'd0 : (64'(pp) << FRAC) / 64'(den);
            gain = (quot > 64'(GAIN_ONE)) ? GAIN_ONE : quot[16:0];
            // Pull the estimate toward the total by gain times the residual.
            resid = track_total[ax] - track_est[ax];
            neg = resid[POS_W-1];
            mag = neg ? -resid : resid;
            prod = 96'(gain) * 96'(mag);
            if (neg)
                track_est[ax] = track_est[ax] - prod[FRAC +: POS_W];
            else
                track_est[ax] = track_est[ax] + prod[FRAC +: POS_W];
            var_prod = 64'(GAIN_ONE - gain) * 64'(pp);
            track_var[ax] = var_prod[FRAC +: 32];
        end
        // Corrected motion: delta plus estimate minus total, saturated.
        resid = track_est[ax] - track_total[ax];
        neg = resid[POS_W-1];
        mag = neg ? -resid : resid;
        if (mag > (48'd1 << 33))
            mag = 48'd1 << 33;
        diff = neg ? -$signed(64'(mag)) : $signed(64'(mag));
        sum = $signed(delta_wide) + diff;
        if (sum > kts_pkg::SAT_HI)
            sum = 64'(kts_pkg::SAT_HI);
        if (sum < kts_pkg::SAT_LO)
            sum = 64'(kts_pkg::SAT_LO);
        return sum[31:0];
    endfunction

    // Reports one failure; only the first ten are printed.
    task automatic report_fault(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, got);
    endtask

    // Model update, expectation queue and result check, all on the rising edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 2; a++)
            begin
                track_total[a] = '0;
                track_est[a]   = '0;
                track_var[a]   = VARIANCE_ONE;
                q_noise[a]     = kts_pkg::PROCESS_NOISE_RESET;
                r_noise[a]     = kts_pkg::MEASUREMENT_NOISE_RESET;
            end
            idle_cycles = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    kts_pkg::REG_PROCESS_NOISE_X:     q_noise[AXIS_X] = cfg_data;
                    kts_pkg::REG_MEASUREMENT_NOISE_X: r_noise[AXIS_X] = cfg_data;
                    kts_pkg::REG_PROCESS_NOISE_Y:     q_noise[AXIS_Y] = cfg_data;
                    kts_pkg::REG_MEASUREMENT_NOISE_Y: r_noise[AXIS_Y] = cfg_data;
                    default: ;
                endcase
            end
            idle_cycles++;
            if (item_valid && !item_stall)
            begin
                idle_cycles = 0;
                predicted.new_delta_x = smooth_axis(AXIS_X, item.delta_x, item.first_frame);
                predicted.new_delta_y = smooth_axis(AXIS_Y, item.delta_y, item.first_frame);
                if (pinned_q.size() != 0)
                begin
                    pin = pinned_q.pop_front();
                    if (pin.pinned)
                        predicted = pin.motion;
                end
                expected_motion = {expected_motion, predicted};
            end
            if (result_valid && !result_stall)
            begin
                idle_cycles = 0;
                if (expected_motion.size() == 0)
                begin
                    report_fault("unexpected result x", 'x, result.new_delta_x);
                end
                else
                begin
                    predicted = expected_motion.pop_front();
                    if (result.new_delta_x !== predicted.new_delta_x)
                        report_fault("new_delta_x", predicted.new_delta_x, result.new_delta_x);
                    if (result.new_delta_y !== predicted.new_delta_y)
                        report_fault("new_delta_y", predicted.new_delta_y, result.new_delta_y);
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver stall pattern: spans of no stall, light, heavy and long stalls.
    initial
    begin
        int stall_mode;
        int stall_span;
        result_stall = 1'b0;
        forever
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(10, 200);
            repeat (stall_span)
            begin
                @(negedge clk);
                if (quiet_phase)
                    result_stall <= 1'b0;
                else
                begin
                    case (stall_mode)
                        0: result_stall <= 1'b0;
                        1: result_stall <= ($urandom_range(0, 3) == 0);
                        2: result_stall <= 1'($urandom_range(0, 1));
                        default: result_stall <= ($urandom_range(0, 15) == 0) ?
                                                 ~result_stall : result_stall;
                    endcase
                end
            end
        end
    end

    // Presents one frame and waits for its transfer, then maybe idles.
    task automatic send_frame(input kts_pkg::item_t frame);
        int gap;
        @(negedge clk);
        item       <= frame;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (!quiet_phase)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                                                  : $urandom_range(0, 6);
                if (gap > 0)
                begin
                    @(negedge clk);
                    item_valid <= 1'b0;
                    item       <= kts_pkg::item_t'({$urandom, $urandom, 1'($urandom)});
                    repeat (gap - 1)
                        @(negedge clk);
                end
            end
        end
    endtask

    // Waits until every expected result has been taken; ends on a falling edge.
    task automatic wait_idle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_motion.size() != 0)
            @(negedge clk);
    endtask

    // Writes one noise register in the next cycle.
    task automatic write_noise(input logic [kts_pkg::CFG_INDEX_WIDTH-1:0] addr,
                               input logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= addr;
        cfg_data  <= value;
    endtask

    // Writes all four noise registers, one per cycle.
    task automatic set_noise(input logic [31:0] qx, input logic [31:0] rx,
                             input logic [31:0] qy, input logic [31:0] ry);
        write_noise(kts_pkg::REG_PROCESS_NOISE_X, qx);
        write_noise(kts_pkg::REG_MEASUREMENT_NOISE_X, rx);
        write_noise(kts_pkg::REG_PROCESS_NOISE_Y, qy);
        write_noise(kts_pkg::REG_MEASUREMENT_NOISE_Y, ry);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [31:0] pick_noise();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return NOISE_MAX;
            2: return $urandom_range(0, 1024);
            3: return $urandom_range(0, 32'h4_0000);
            default: return $urandom;
        endcase
    endfunction

    // Mostly camera-sized motion, with extremes and full-range values mixed in.
    function automatic logic [31:0] pick_delta();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return DELTA_MAX;
                    1: return DELTA_MIN;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'd1;
                endcase
            end
            2, 3, 4: return $urandom;
            default: return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
        endcase
    endfunction

    task automatic add_row(input logic pinned, input logic first, input logic [31:0] dx,
                           input logic [31:0] dy, input logic [31:0] want_x,
                           input logic [31:0] want_y);
        frame_row_t row;
        row.pinned             = pinned;
        row.frame.delta_x      = dx;
        row.frame.delta_y      = dy;
        row.frame.first_frame  = first;
        row.motion.new_delta_x = want_x;
        row.motion.new_delta_y = want_y;
        frame_table = {frame_table, row};
    endtask

    initial
    begin
        kts_pkg::item_t frame;
        pinned_t        entry;
        clk         = 1'b0;
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        fault_count = 0;
        burst_left  = 0;
        quiet_phase = 1'b0;

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset noise setting. The first three
        // restart the filters with the estimate at zero, so their results
        // are known by hand: the second one saturates on y.
        //      pinned first  delta_x        delta_y        want_x         want_y
        add_row(1'b1,  1'b1,  DELTA_MAX,     DELTA_MIN,     32'h0000_0000, 32'h0000_0000);
        add_row(1'b1,  1'b1,  32'h8000_0001, DELTA_MAX,     32'h8000_0001, DELTA_MAX);
        add_row(1'b1,  1'b1,  32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0001);
        add_row(1'b0,  1'b0,  32'h0000_0000, 32'h0000_0000, '0, '0);
        add_row(1'b0,  1'b0,  DELTA_MAX,     DELTA_MIN,     '0, '0);
        add_row(1'b0,  1'b0,  DELTA_MAX,     DELTA_MIN,     '0, '0);
        add_row(1'b0,  1'b0,  DELTA_MIN,     DELTA_MAX,     '0, '0);
        add_row(1'b0,  1'b0,  DELTA_MIN,     DELTA_MAX,     '0, '0);
        add_row(1'b0,  1'b0,  DELTA_MIN,     DELTA_MAX,     '0, '0);
        add_row(1'b0,  1'b0,  DELTA_MAX,     DELTA_MIN,     '0, '0);
        add_row(1'b0,  1'b0,  32'hFFFF_FFFF, 32'h0000_0001, '0, '0);
        add_row(1'b0,  1'b0,  32'h0001_0000, 32'hFFFF_0000, '0, '0);
        add_row(1'b0,  1'b0,  32'h5555_5555, 32'hAAAA_AAAA, '0, '0);
        add_row(1'b0,  1'b0,  32'hAAAA_AAAA, 32'h5555_5555, '0, '0);
        add_row(1'b0,  1'b1,  32'h1234_5678, 32'hEDCB_A988, '0, '0);
        add_row(1'b0,  1'b0,  32'h0000_0000, 32'h0000_0000, '0, '0);
        add_row(1'b0,  1'b0,  32'h0000_0001, 32'hFFFF_FFFF, '0, '0);
        add_row(1'b0,  1'b1,  DELTA_MAX,     DELTA_MAX,     '0, '0);
        add_row(1'b0,  1'b0,  DELTA_MIN,     DELTA_MIN,     '0, '0);
        add_row(1'b0,  1'b0,  32'h0000_0000, 32'h0000_0000, '0, '0);

        foreach (frame_table[i])
        begin
            entry.pinned = frame_table[i].pinned;
            entry.motion = frame_table[i].motion;
            pinned_q = {pinned_q, entry};
            send_frame(frame_table[i].frame);
        end

        // Random phases, each under its own noise setting. The first four
        // cover zero noise (gain of one, then a zero denominator), saturating
        // variance, and the two mixed extremes; then the reset values.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0: set_noise(32'd0, 32'd0, 32'd0, 32'd0);
                1: set_noise(NOISE_MAX, NOISE_MAX, NOISE_MAX, NOISE_MAX);
                2: set_noise(NOISE_MAX, 32'd0, 32'd0, NOISE_MAX);
                3: set_noise(32'd0, NOISE_MAX, NOISE_MAX, 32'd0);
                4: set_noise(kts_pkg::PROCESS_NOISE_RESET, kts_pkg::MEASUREMENT_NOISE_RESET,
                             kts_pkg::PROCESS_NOISE_RESET, kts_pkg::MEASUREMENT_NOISE_RESET);
                default: set_noise(pick_noise(), pick_noise(), pick_noise(), pick_noise());
            endcase
            repeat (PHASE_FRAMES)
            begin
                frame.delta_x     = pick_delta();
                frame.delta_y     = pick_delta();
                frame.first_frame = ($urandom_range(0, 19) == 0);
                send_frame(frame);
            end
        end

        // Drift phase: with no measurement noise the gain is one, and large
        // steps carry x up and y down back to back with no receiver stalls.
        wait_idle();
        set_noise(kts_pkg::PROCESS_NOISE_RESET, 32'd0, kts_pkg::PROCESS_NOISE_RESET, 32'd0);
        quiet_phase = 1'b1;
        frame.first_frame = 1'b0;
        repeat (DRIFT_FRAMES)
        begin
            frame.delta_x = ($urandom_range(0, 3) == 0) ? pick_delta() : DELTA_MAX;
            frame.delta_y = ($urandom_range(0, 3) == 0) ? pick_delta() : DELTA_MIN;
            send_frame(frame);
        end
        quiet_phase = 1'b0;

        wait_idle();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fault_count == 0 && expected_motion.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
